[rtl/cclc_pkg.sv]
package cclc_pkg;

    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned ROLE_W    = 3;
    localparam int unsigned STATUS_W  = 3;
    localparam logic [COUNT_W-1:0] PREFIX_LEN = 8'd8;

    // Byte roles.
    localparam logic [ROLE_W-1:0] ROLE_PREFIX  = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_SEP     = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_NONCE   = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_SESSION = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_EXTRA   = 3'd4;

    // Line verdicts.
    localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_PREFIX  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_NONCE   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SESSION = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY    = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [COUNT_W-1:0] chunk_count;
        logic               prefix_bad;
        logic               content_cut;
        logic [1:0]         token_number;
        logic               inside_token;
        logic [7:0]         token_length;
        logic               nonce_bad;
        logic               session_bad;
    } line_state_t;

    typedef struct packed {
        logic [7:0]          echo_byte;
        logic [ROLE_W-1:0]   byte_role;
        logic                line_end;
        logic [STATUS_W-1:0] line_status;
        logic                has_session;
    } result_t;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "C";
            3'd1:    c = "A";
            3'd2:    c = "P";
            3'd3:    c = "T";
            3'd4:    c = "U";
            3'd5:    c = "R";
            3'd6:    c = "E";
            default: c = " ";
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_lower_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f"));
    endfunction

    function automatic logic is_session_char(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               is_digit(c) || (c == "-") || (c == "_") || (c == ".") || (c == ":");
    endfunction

endpackage

[rtl/cclc_step.sv]
module cclc_step #(
    parameter int unsigned LINE_BUFFER   = 256,
    parameter int unsigned NONCE_CHARS   = 64,
    parameter int unsigned SESSION_LIMIT = 128
) (
    input  cclc_pkg::line_state_t state,
    input  logic [7:0]            in_byte,
    output cclc_pkg::line_state_t state_next,
    output cclc_pkg::result_t     result
);
    import cclc_pkg::*;

    localparam logic [COUNT_W-1:0] LAST_POS  = COUNT_W'(LINE_BUFFER - 2);
    localparam logic [7:0]         NONCE_LEN = 8'(NONCE_CHARS);
    localparam logic [8:0]         SESS_MAX  = 9'(SESSION_LIMIT);

    line_state_t          upd;
    logic                 is_cut_char;
    logic                 is_blank;
    logic                 sep_close;
    logic                 last;
    logic [ROLE_W-1:0]    role;
    logic [STATUS_W-1:0]  status;
    logic                 sess;

    always_comb
    begin
        upd         = state;
        role        = ROLE_SEP;
        sep_close   = 1'b0;
        is_cut_char = (in_byte == CH_CR) || (in_byte == CH_LF) || (in_byte == CH_NUL);
        is_blank    = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

        if (state.chunk_count < PREFIX_LEN)
        begin
            role = ROLE_PREFIX;
            if (in_byte != prefix_char(state.chunk_count[2:0]))
            begin
                upd.prefix_bad = 1'b1;
            end
        end
        else if (state.prefix_bad || state.content_cut)
        begin
            role = ROLE_SEP;
        end
        else if (is_cut_char)
        begin
            upd.content_cut = 1'b1;
            sep_close       = 1'b1;
        end
        else if (is_blank)
        begin
            sep_close = 1'b1;
        end
        else
        begin
            if (!state.inside_token)
            begin
                upd.inside_token = 1'b1;
                upd.token_length = 8'd0;
                if (state.token_number != 2'd3)
                begin
                    upd.token_number = state.token_number + 2'd1;
                end
            end
            if (upd.token_length != 8'hFF)
            begin
                upd.token_length = upd.token_length + 8'd1;
            end
            case (upd.token_number)
                2'd1:
                begin
                    role = ROLE_NONCE;
                    if (!is_lower_hex(in_byte))
                    begin
                        upd.nonce_bad = 1'b1;
                    end
                end
                2'd2:
                begin
                    role = ROLE_SESSION;
                    if (!is_session_char(in_byte))
                    begin
                        upd.session_bad = 1'b1;
                    end
                end
                default: role = ROLE_EXTRA;
            endcase
        end

        last = (in_byte == CH_LF) || (state.chunk_count >= LAST_POS);

        // A separator closes the open token; so does the end of a chunk with a good prefix.
        // Closing twice is harmless, as the second close finds no open token.
        if ((sep_close || (last && !upd.prefix_bad)) && upd.inside_token)
        begin
            if ((upd.token_number == 2'd1) && (upd.token_length != NONCE_LEN))
            begin
                upd.nonce_bad = 1'b1;
            end
            if ((upd.token_number == 2'd2) && ({1'b0, upd.token_length} >= SESS_MAX))
            begin
                upd.session_bad = 1'b1;
            end
            upd.inside_token = 1'b0;
        end

        if (upd.prefix_bad)
        begin
            status = STATUS_BAD_PREFIX;
        end
        else if ((upd.token_number == 2'd0) || upd.nonce_bad)
        begin
            status = STATUS_BAD_NONCE;
        end
        else if (upd.session_bad)
        begin
            status = STATUS_BAD_SESSION;
        end
        else if (upd.token_number == 2'd3)
        begin
            status = STATUS_TOO_MANY;
        end
        else
        begin
            status = STATUS_OK;
        end
        sess = !upd.prefix_bad && (upd.token_number >= 2'd2);

        upd.chunk_count = state.chunk_count + 8'd1;

        if (last)
        begin
            state_next = '0;
        end
        else
        begin
            state_next = upd;
        end

        result.echo_byte   = in_byte;
        result.byte_role   = role;
        result.line_end    = last;
        result.line_status = last ? status : STATUS_OK;
        result.has_session = last && sess;
    end

endmodule

[rtl/capture_command_line_checker.sv]
// Channel | Handshake             | Word
// --------+-----------------------+---------------------------------------------------
// input   | in_valid / in_ready   | in_byte
// output  | out_valid / out_ready | echo_byte, byte_role, line_end, line_status,
//         |                       | has_session
//
// One word in, one word out; a new byte is taken every cycle unless the output stalls.
// Output is registered; the line state and the result register load on the same edge.
// The result register frees in the cycle it is taken, so in_ready = !out_valid | out_ready.
// Reset (rst_n low) clears the line state and empties the result register.
// A stall on the output holds the line state until the pending word is taken.
module capture_command_line_checker #(
    parameter int unsigned LINE_BUFFER   = 256,
    parameter int unsigned NONCE_CHARS   = 64,
    parameter int unsigned SESSION_LIMIT = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      echo_byte,
    output logic [cclc_pkg::ROLE_W-1:0]     byte_role,
    output logic                            line_end,
    output logic [cclc_pkg::STATUS_W-1:0]   line_status,
    output logic                            has_session
);
    import cclc_pkg::*;

    localparam logic [COUNT_W-1:0] LAST_POS = COUNT_W'(LINE_BUFFER - 2);

    line_state_t state_reg;
    line_state_t state_next;
    result_t     result_reg;
    result_t     result_next;
    logic        out_valid_reg;
    logic        accept;

    cclc_step #(
        .LINE_BUFFER   (LINE_BUFFER),
        .NONCE_CHARS   (NONCE_CHARS),
        .SESSION_LIMIT (SESSION_LIMIT)
    ) u_step (
        .state      (state_reg),
        .in_byte    (in_byte),
        .state_next (state_next),
        .result     (result_next)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign echo_byte   = result_reg.echo_byte;
    assign byte_role   = result_reg.byte_role;
    assign line_end    = result_reg.line_end;
    assign line_status = result_reg.line_status;
    assign has_session = result_reg.has_session;

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.chunk_count <= LAST_POS)
        else $error("chunk count ran past the chunk length");

    a_newline_ends_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_byte == CH_LF)) |=> (out_valid && line_end))
        else $error("newline did not close the chunk");

    a_state_cleared_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (!line_end || (state_reg == '0)))
        else $error("line state not cleared after chunk end");

    a_quiet_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !line_end) |-> ((line_status == STATUS_OK) && !has_session))
        else $error("verdict shown before chunk end");

    a_no_session_on_bad_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (line_status == STATUS_BAD_PREFIX)) |-> !has_session)
        else $error("session flagged on a chunk with a bad prefix");
`endif

endmodule

[bench/line_verdict_checker.sv]
module line_verdict_checker #(
    parameter int unsigned LINE_BUFFER   = 256,
    parameter int unsigned NONCE_CHARS   = 64,
    parameter int unsigned SESSION_LIMIT = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [7:0]                    in_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [7:0]                    echo_byte,
    input  logic [cclc_pkg::ROLE_W-1:0]   byte_role,
    input  logic                          line_end,
    input  logic [cclc_pkg::STATUS_W-1:0] line_status,
    input  logic                          has_session,
    output int                            mismatches,
    output int                            words_due
);
    import cclc_pkg::*;

    localparam logic [63:0] COMMAND_WORD = "CAPTURE ";

    result_t    pending_words[$];
    int         fail_count;

    // Shadow of the line state.
    logic [7:0] line_pos;
    logic       lead_bad;
    logic       cut_seen;
    logic [1:0] tok_count;
    logic       in_tok;
    logic [7:0] tok_len;
    logic       nonce_err;
    logic       sess_err;

    function automatic void clear_line();
        line_pos  = '0;
        lead_bad  = 1'b0;
        cut_seen  = 1'b0;
        tok_count = '0;
        in_tok    = 1'b0;
        tok_len   = '0;
        nonce_err = 1'b0;
        sess_err  = 1'b0;
    endfunction

    function automatic void finish_token();
        if (in_tok)
        begin
            if (tok_count == 2'd1 && int'(tok_len) != NONCE_CHARS)
                nonce_err = 1'b1;
            if (tok_count == 2'd2 && int'(tok_len) >= SESSION_LIMIT)
                sess_err = 1'b1;
            in_tok = 1'b0;
        end
    endfunction

    function automatic result_t predict_word(input logic [7:0] b);
        result_t r;
        logic    closes;
        logic    hex_ok;
        logic    sess_ok;
        r = '0;
        r.echo_byte = b;
        r.byte_role = ROLE_SEP;
        hex_ok  = (b >= "0" && b <= "9") || (b >= "a" && b <= "f");
        sess_ok = (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
                  (b >= "A" && b <= "Z") || b == "-" || b == "_" || b == "." || b == ":";
        if (line_pos < PREFIX_LEN)
        begin
            r.byte_role = ROLE_PREFIX;
            if (b != COMMAND_WORD[(7 - int'(line_pos)) * 8 +: 8])
                lead_bad = 1'b1;
        end
        else if (lead_bad || cut_seen)
        begin
            r.byte_role = ROLE_SEP;
        end
        else if (b == CH_CR || b == CH_LF || b == CH_NUL)
        begin
            cut_seen = 1'b1;
            finish_token();
        end
        else if (b == CH_SPACE || b == CH_TAB)
        begin
            finish_token();
        end
        else
        begin
            if (!in_tok)
            begin
                in_tok  = 1'b1;
                tok_len = '0;
                if (tok_count != 2'd3)
                    tok_count = tok_count + 2'd1;
            end
            if (tok_len != 8'hFF)
                tok_len = tok_len + 8'd1;
            if (tok_count == 2'd1)
            begin
                r.byte_role = ROLE_NONCE;
                if (!hex_ok)
                    nonce_err = 1'b1;
            end
            else if (tok_count == 2'd2)
            begin
                r.byte_role = ROLE_SESSION;
                if (!sess_ok)
                    sess_err = 1'b1;
            end
            else
            begin
                r.byte_role = ROLE_EXTRA;
            end
        end

        // A chunk closes on a newline or when the line buffer is full.
        closes = (b == CH_LF) || (int'(line_pos) + 1 >= LINE_BUFFER - 1);
        line_pos = line_pos + 8'd1;
        if (closes)
        begin
            if (!lead_bad)
                finish_token();
            r.line_end = 1'b1;
            if (lead_bad)
                r.line_status = STATUS_BAD_PREFIX;
            else if (tok_count == 2'd0 || nonce_err)
                r.line_status = STATUS_BAD_NONCE;
            else if (sess_err)
                r.line_status = STATUS_BAD_SESSION;
            else if (tok_count == 2'd3)
                r.line_status = STATUS_TOO_MANY;
            else
                r.line_status = STATUS_OK;
            r.has_session = !lead_bad && tok_count >= 2'd2;
            clear_line();
        end
        return r;
    endfunction

    function automatic void check_field(input string label, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_line();
            pending_words.delete();
            fail_count = 0;
            mismatches <= 0;
            words_due  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: word with no prediction, expected none actual echo %0d",
                             $time, echo_byte);
                    fail_count++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    check_field("echo_byte", want.echo_byte, echo_byte);
                    check_field("byte_role", want.byte_role, byte_role);
                    check_field("line_end", want.line_end, line_end);
                    check_field("line_status", want.line_status, line_status);
                    check_field("has_session", want.has_session, has_session);
                end
            end
            if (in_valid && in_ready)
                pending_words.push_back(predict_word(in_byte));
            mismatches <= fail_count;
            words_due  <= pending_words.size();
        end
    end

endmodule

[bench/capture_command_line_checker_test.sv]
module capture_command_line_checker_test;
    import cclc_pkg::*;

    localparam string HEX_CHARS  = "0123456789abcdef";
    localparam string SESS_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.:";

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic [7:0]          in_byte   = 8'h00;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic [7:0]          echo_byte;
    logic [ROLE_W-1:0]   byte_role;
    logic                line_end;
    logic [STATUS_W-1:0] line_status;
    logic                has_session;
    int                  mismatches;
    int                  words_due;

    logic [7:0]          line_q[$];
    int                  burst_left  = 0;
    int                  sent_total  = 0;
    int                  stall_mode  = 0;
    int                  stall_phase = 0;

    capture_command_line_checker dut (.*);

    line_verdict_checker checker_u (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("Regression FAIL");
        $finish;
    end

    // The receiver picks a new stall pattern whenever its phase counter runs out.
    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= $urandom_range(20, 200);
        end
        else
        begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= (stall_phase % 4) != 0;
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_word(input logic [7:0] b);
        int   gap;
        logic taken;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 50);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        // in_ready is settled by the falling edge and holds until the next rising one.
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        burst_left--;
        sent_total++;
    endtask

    task automatic wait_all_words();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    task automatic put_hex(input int n);
        for (int i = 0; i < n; i++)
            line_q.push_back(HEX_CHARS[$urandom_range(0, 15)]);
    endtask

    task automatic put_session(input int n);
        for (int i = 0; i < n; i++)
            line_q.push_back(SESS_CHARS[$urandom_range(0, SESS_CHARS.len() - 1)]);
    endtask

    task automatic put_gap();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) line_q.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB);
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++)
            line_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic send_line();
        while (line_q.size() != 0)
            send_word(line_q.pop_front());
    endtask

    task automatic build_random_line();
        int    kind;
        int    n;
        string lead_text;
        lead_text = "CAPTURE ";
        kind = $urandom_range(0, 19);
        if (kind < 12)
        begin
            put_text("CAPTURE ");
            if ($urandom_range(0, 5) == 0)
                line_q[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                put_gap();
            case ($urandom_range(0, 9))
                0:       put_hex($urandom_range(0, 70));
                1:
                begin
                    put_hex(63);
                    line_q.push_back(8'($urandom_range(8'h21, 8'hFF)));
                end
                default: put_hex(64);
            endcase
            if ($urandom_range(0, 2) != 0)
            begin
                put_gap();
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(120, 135)
                                                : $urandom_range(1, 24);
                put_session(n);
                if ($urandom_range(0, 7) == 0)
                    line_q.push_back(8'($urandom_range(8'h21, 8'hFF)));
            end
            if ($urandom_range(0, 5) == 0)
            begin
                put_gap();
                put_session($urandom_range(1, 5));
            end
            if ($urandom_range(0, 3) == 0)
                put_gap();
            if ($urandom_range(0, 5) == 0)
            begin
                line_q.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_NUL);
                put_noise($urandom_range(0, 10));
            end
            if ($urandom_range(0, 19) != 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    line_q.push_back(CH_CR);
                line_q.push_back(CH_LF);
            end
        end
        else if (kind < 16)
        begin
            put_noise($urandom_range(1, 30));
            line_q.push_back(CH_LF);
        end
        else if (kind < 19)
        begin
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++)
                line_q.push_back(lead_text[i]);
            line_q.push_back(CH_LF);
        end
        else
        begin
            put_text("CAPTURE ");
            put_hex(64);
            put_gap();
            put_session($urandom_range(200, 400));
            line_q.push_back(CH_LF);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // A well-formed line with only a nonce.
        put_text("CAPTURE "); put_hex(64); line_q.push_back(CH_LF); send_line();
        // Short lines and a wrong prefix.
        put_text("CAP"); line_q.push_back(CH_LF); send_line();
        line_q.push_back(CH_LF); send_line();
        put_text("capture "); put_hex(8); line_q.push_back(CH_LF); send_line();
        // No nonce at all, or only separators.
        put_text("CAPTURE "); line_q.push_back(CH_LF); send_line();
        put_text("CAPTURE   \t "); line_q.push_back(CH_LF); send_line();
        // Nonce one short, and with an upper-case digit.
        put_text("CAPTURE "); put_hex(63); line_q.push_back(CH_LF); send_line();
        put_text("CAPTURE "); put_hex(63); put_text("A"); line_q.push_back(CH_LF);
        send_line();
        // Session one too long.
        put_text("CAPTURE "); put_hex(64); put_text(" "); put_session(128);
        line_q.push_back(CH_LF); send_line();
        // Too many tokens, and the order in which the verdicts win.
        put_text("CAPTURE "); put_hex(64); put_text(" s1 extra"); line_q.push_back(CH_LF);
        send_line();
        put_text("CAPTURE "); put_hex(10); put_text(" b!d more"); line_q.push_back(CH_LF);
        send_line();
        put_text("CAPTURE "); put_hex(64); put_text(" b!d more"); line_q.push_back(CH_LF);
        send_line();
        // Content stopped by a NUL after a good session.
        put_text("CAPTURE "); put_hex(64); put_text(" s:2"); line_q.push_back(CH_NUL);
        put_text(" a b c"); line_q.push_back(CH_LF); send_line();
        // Byte extremes in a session and in the prefix.
        put_text("CAPTURE "); put_hex(64); put_text(" ");
        line_q.push_back(8'hFF); line_q.push_back(8'h80); line_q.push_back(CH_LF);
        send_line();
        line_q.push_back(8'hFF); line_q.push_back(CH_NUL); line_q.push_back(8'h7F);
        line_q.push_back(CH_LF); send_line();
        // A session at its longest, then an extra token cut by the buffer limit,
        // and a newline landing just past it.
        put_text("CAPTURE "); put_hex(64); put_text(" "); put_session(127);
        put_text(" "); put_session(54);
        line_q.push_back(CH_LF); send_line();

        wait_all_words();

        while (sent_total < 1200)
        begin
            build_random_line();
            send_line();
            if ($urandom_range(0, 14) == 0)
                wait_all_words();
        end

        wait_all_words();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && words_due == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
